### hw/rtl/sbg_pkg.sv
// ----------------------------------------------------------------------------
// sbg_pkg - shared definitions for the S-box gate network
// Word width and the word type used by the pipeline and the gate network.
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int unsigned WORD_W = 8;

  typedef logic [WORD_W-1:0] word_t;

endpackage

### hw/rtl/sbg_net.sv
// ----------------------------------------------------------------------------
// sbg_net - forward AES S-box as a fixed XOR/AND gate network
// Linear top layer, shared nonlinear middle layer, linear bottom layer.
// ----------------------------------------------------------------------------
module sbg_net
  import sbg_pkg::*;
(
  input  word_t din,
  output word_t dout
);

  // Wires are evaluated in a fixed order; all but a (the input) start at zero.
  function automatic word_t sbox_eval(input word_t v);
    logic [7:0]  a;
    logic [20:0] l;
    logic [49:0] n;
    logic [17:0] p;
    logic [7:0]  o;
    word_t       r;
    a = v;
    l = '0;
    n = '0;
    p = '0;
    o = '0;

    // top linear layer
    a[0] ^= 1'b1; a[6] ^= 1'b1; l[0] ^= 1'b1; l[1] ^= 1'b1; l[3] ^= a[1]; l[4] ^= 1'b1;
    l[6] ^= a[3]; l[7] ^= 1'b1;
    l[8] ^= a[4]; l[11] ^= a[7]; l[12] ^= 1'b1; l[13] ^= a[5]; l[16] ^= a[2];
    n[24] ^= 1'b1; n[29] ^= 1'b1; n[44] ^= 1'b1; n[47] ^= 1'b1; n[48] ^= 1'b1; n[49] ^= 1'b1;
    l[2] ^= a[6]; l[4] ^= a[1]; l[6] ^= a[7]; l[8] ^= a[5]; l[9] ^= a[0]; l[12] ^= a[2];
    l[13] ^= a[3]; l[16] ^= a[4];
    l[0] ^= l[6]; l[1] ^= a[3]; l[4] ^= a[5]; l[7] ^= l[8]; l[10] ^= a[1]; l[11] ^= a[0];
    l[12] ^= a[6];
    l[13] ^= 1'b1; l[14] ^= l[9]; l[16] ^= a[7]; n[26] ^= a[2]; n[31] ^= a[4];
    l[1] ^= a[0]; l[2] ^= a[3]; l[6] ^= a[1]; l[8] ^= a[7]; l[9] ^= a[5]; l[10] ^= l[12];
    l[11] ^= a[2];
    l[14] ^= a[4]; l[16] ^= l[4]; n[24] ^= a[6];
    l[0] ^= a[0]; l[1] ^= a[5]; l[7] ^= a[2]; l[9] ^= a[1]; l[11] ^= a[4]; l[14] ^= l[13];
    l[15] ^= l[16];
    n[24] ^= a[3]; n[28] ^= a[6]; n[29] ^= a[7];
    l[0] ^= a[4]; l[2] ^= l[11]; l[3] ^= l[1]; l[7] ^= a[3]; l[9] ^= 1'b1; l[13] ^= a[7];
    l[14] ^= a[2];
    l[15] ^= a[6]; n[24] ^= a[5]; n[26] ^= a[0]; n[31] ^= a[1];
    n[26] ^= a[4]; n[29] ^= a[2]; n[33] ^= a[3]; n[34] ^= a[6]; n[35] ^= a[5]; n[44] ^= a[7];

    // first products
    n[4] ^= l[7] & l[3]; n[5] ^= l[15] & l[16]; n[6] ^= l[6] & l[2]; n[7] ^= l[13] & l[12];
    n[8] ^= l[11] & l[10]; n[9] ^= l[14] & a[1]; n[10] ^= a[0] & l[1]; n[11] ^= l[9] & l[8];
    n[12] ^= l[4] & l[0];

    // middle layer
    n[24] ^= n[4]; n[26] ^= a[1]; n[28] ^= n[5]; n[29] ^= n[11]; n[31] ^= n[6]; n[33] ^= a[2];
    n[34] ^= a[0]; n[35] ^= a[3]; n[37] ^= n[10]; n[41] ^= a[4]; n[42] ^= n[12];
    n[44] ^= n[8];
    n[45] ^= a[6]; n[46] ^= a[7]; n[47] ^= n[7]; n[48] ^= a[5]; n[49] ^= n[9];
    n[24] ^= n[6]; n[26] ^= n[4]; n[28] ^= n[10]; n[29] ^= n[5]; n[31] ^= a[0]; n[33] ^= a[5];
    n[34] ^= a[2]; n[35] ^= a[7]; n[37] ^= a[4]; n[41] ^= a[1]; n[44] ^= n[12];
    n[45] ^= n[11];
    n[46] ^= a[3]; n[47] ^= n[8]; n[48] ^= n[9]; n[49] ^= a[6];
    n[24] ^= n[8]; n[26] ^= n[6]; n[28] ^= n[4]; n[29] ^= n[7]; n[31] ^= a[2]; n[33] ^= a[7];
    n[34] ^= a[1]; n[35] ^= n[5]; n[37] ^= n[12]; n[41] ^= a[0]; n[42] ^= a[4];
    n[44] ^= a[6];
    n[45] ^= n[10]; n[46] ^= n[9]; n[48] ^= a[3]; n[49] ^= a[5];
    n[24] ^= n[9]; n[26] ^= n[10]; n[28] ^= n[11]; n[29] ^= n[4]; n[31] ^= n[12];
    n[33] ^= n[5];
    n[34] ^= a[4]; n[35] ^= n[6]; n[37] ^= a[0]; n[41] ^= a[2]; n[42] ^= a[1]; n[44] ^= n[7];
    n[46] ^= a[5]; n[47] ^= a[7]; n[48] ^= n[8]; n[49] ^= a[3];
    n[24] ^= n[10]; n[26] ^= n[12]; n[29] ^= n[8]; n[31] ^= n[4]; n[33] ^= n[6];
    n[34] ^= n[5];
    n[35] ^= a[2]; n[37] ^= a[1]; n[41] ^= a[6]; n[42] ^= a[0]; n[44] ^= n[11];
    n[46] ^= a[4];
    n[24] ^= n[11]; n[29] ^= a[6]; n[31] ^= n[10]; n[33] ^= n[9]; n[34] ^= n[6];
    n[35] ^= n[7];
    n[37] ^= a[2]; n[41] ^= n[12]; n[42] ^= n[4]; n[44] ^= n[5]; n[46] ^= a[0];
    n[47] ^= a[1];
    n[49] ^= n[8];
    n[29] ^= n[12]; n[30] ^= n[24] & n[28]; n[33] ^= n[7]; n[34] ^= n[11]; n[35] ^= n[9];
    n[37] ^= n[6]; n[41] ^= n[5]; n[42] ^= a[2]; n[44] ^= n[4]; n[46] ^= a[1];
    n[47] ^= a[0];
    n[49] ^= n[10];
    n[31] ^= n[30]; n[33] ^= n[10]; n[35] ^= n[12]; n[37] ^= n[4]; n[41] ^= n[11];
    n[42] ^= n[6];
    n[44] ^= a[2]; n[45] ^= n[5]; n[46] ^= n[7]; n[47] ^= a[4];
    n[32] ^= n[29] & n[31]; n[33] ^= n[12]; n[35] ^= n[10]; n[41] ^= n[6]; n[39] ^= n[30];
    n[45] ^= n[4]; n[46] ^= n[5]; n[49] ^= n[11];
    n[33] ^= n[32]; n[34] ^= n[12]; n[35] ^= n[30]; n[42] ^= n[10]; n[46] ^= n[4];
    n[47] ^= n[6];
    n[48] ^= n[5];
    n[36] ^= n[34] & n[35]; n[42] ^= n[30]; n[46] ^= n[32]; n[47] ^= n[4]; n[48] ^= n[6];
    n[39] ^= n[36]; n[48] ^= n[32]; n[49] ^= n[4];
    n[40] ^= n[26] & n[39]; n[37] ^= n[36]; n[49] ^= n[6];
    n[41] ^= n[36]; n[42] ^= n[40]; n[49] ^= n[32];
    n[41] ^= n[40]; n[43] ^= n[33] & n[42]; n[47] ^= n[36];
    n[45] ^= n[40]; n[46] ^= n[36]; n[47] ^= n[43];
    n[47] ^= n[40]; n[48] ^= n[43];
    n[44] ^= n[43]; n[48] ^= n[40];
    n[49] ^= n[43];

    // final products
    p[11] ^= n[33] & l[1]; p[17] ^= n[37] & l[3]; p[15] ^= n[41] & l[2];
    p[9] ^= n[44] & l[0];
    p[7] ^= n[45] & l[16]; p[12] ^= n[46] & a[1]; p[13] ^= n[47] & l[12];
    p[5] ^= n[48] & l[11];
    p[10] ^= n[49] & l[8];
    p[2] ^= n[33] & a[0]; p[8] ^= n[37] & l[7]; p[6] ^= n[41] & l[6]; p[0] ^= n[44] & l[4];
    p[16] ^= n[45] & l[15]; p[3] ^= n[46] & l[14]; p[4] ^= n[47] & l[13];
    p[14] ^= n[48] & l[10];
    p[1] ^= n[49] & l[9];

    // bottom linear layer
    o[0] ^= 1'b1; o[3] ^= 1'b1; o[6] ^= 1'b1; o[7] ^= 1'b1;
    o[0] ^= p[9]; o[1] ^= p[5]; o[2] ^= p[3]; o[3] ^= p[1]; o[4] ^= p[12]; o[5] ^= p[10];
    o[6] ^= p[4]; o[7] ^= p[2];
    o[0] ^= p[15]; o[1] ^= p[6]; o[2] ^= p[4]; o[3] ^= p[2]; o[4] ^= p[16]; o[5] ^= p[1];
    o[6] ^= p[3]; o[7] ^= p[0];
    o[0] ^= p[16]; o[1] ^= p[8]; o[2] ^= p[7]; o[3] ^= p[3]; o[5] ^= p[11]; o[6] ^= p[2];
    o[7] ^= o[4];
    o[0] ^= p[10]; o[1] ^= p[11]; o[2] ^= p[8]; o[3] ^= p[16]; o[4] ^= p[14];
    o[5] ^= p[13];
    o[6] ^= p[15]; o[7] ^= p[3];
    o[1] ^= o[3]; o[2] ^= p[10]; o[4] ^= p[15]; o[6] ^= o[5]; o[7] ^= p[4];
    o[1] ^= p[10]; o[2] ^= p[11]; o[3] ^= p[12]; o[5] ^= p[0]; o[6] ^= p[14];
    o[7] ^= p[13];
    o[1] ^= p[13]; o[2] ^= p[12]; o[3] ^= p[4]; o[5] ^= p[6]; o[6] ^= p[16]; o[7] ^= p[7];
    o[1] ^= p[14]; o[2] ^= p[13]; o[3] ^= p[17]; o[5] ^= p[7]; o[7] ^= p[6];
    o[1] ^= p[15]; o[3] ^= p[13]; o[5] ^= p[12]; o[7] ^= p[17];

    // output wire i lands in bit 7-i
    for (int i = 0; i < WORD_W; i++) begin
      r[WORD_W-1-i] = o[i];
    end
    return r;
  endfunction

  assign dout = sbox_eval(din);

endmodule

### hw/rtl/sbox_gate_network.sv
// ----------------------------------------------------------------------------
// sbox_gate_network - pipelined forward AES byte substitution
// Input register, gate network, result register; one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel byte_in/in_valid/in_ready and output channel
//   byte_out/out_valid/out_ready, both valid/ready. A word moves when
//   valid and ready are high at the same rising edge.
//   A word accepted into the input register passes through the gate
//   network into the result register and is then offered on byte_out.
//   Throughput: one word per cycle unless stalled. The gate network between
//   the input register and the result register sets the clock period.
//   Stall: when out_ready is low the result register holds its word; the
//   input register still takes one more word, then in_ready drops until
//   the receiver drains the result register.
//   Reset (rst, synchronous): both stage valid flags clear, so no word is
//   in flight afterwards. No state is kept between words.
// ----------------------------------------------------------------------------
module sbox_gate_network
  import sbg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  word_t byte_in,
  input  logic  in_valid,
  output logic  in_ready,
  output word_t byte_out,
  output logic  out_valid,
  input  logic  out_ready
);

  logic  s1_valid;
  word_t s1_data;
  word_t net_out;
  logic  s1_adv;

  // result register free or draining this cycle
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= byte_in;
    end
  end

  sbg_net u_net (
    .din  (s1_data),
    .dout (net_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      byte_out <= net_out;
    end
  end

`ifndef ASSERT_OFF
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word did not reach the input register");

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> (out_valid && byte_out == $past(net_out)))
    else $error("result register did not capture the network output");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
